@@ hw/rtl/extendible_hash_table_core_assert.svh @@
// Assertion macros for the hash table core.
`ifndef EXTENDIBLE_HASH_TABLE_CORE_ASSERT_SVH
`define EXTENDIBLE_HASH_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EHT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EHT_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");
`else
`define EHT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define EHT_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ hw/rtl/eht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eht_pkg
// Shared constants and types for the extendible hash table core.
// ----------------------------------------------------------------------------
package eht_pkg;
  localparam int BucketSlots     = 4;
  localparam int BucketIndexBits = 6;
  localparam int MaxGlobalDepth  = 6;
  localparam int MaxSegments     = 64;
  localparam int KeyW            = 64;
  localparam int CfgW            = 7;

  localparam logic CFG_INIT_DEPTH = 1'b0;
  localparam logic CFG_KEY_BITS   = 1'b1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  // Prefix of key at depth d, key width kb (1..64).
  function automatic logic [15:0] prefix_of(input logic [63:0] k, input logic [6:0] kb,
                                            input logic [4:0] d);
    logic [6:0]  sh;
    logic [63:0] m;
    logic [63:0] s;
    begin
      sh = (kb > {2'b0, d}) ? kb - {2'b0, d} : 7'd0;
      m  = (64'd1 << d) - 64'd1;
      s  = k >> sh;
      prefix_of = (d == 5'd0) ? 16'd0 : s[15:0] & m[15:0];
    end
  endfunction
endpackage

@@ hw/rtl/extendible_hash_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extendible_hash_table_core
// Extendible hash table with segment split and directory doubling.
// ----------------------------------------------------------------------------
// Usage:
//  - A command transaction (op, key, value) is accepted when start is high
//    and busy is low. One result per command: read_value, hit and status on
//    a one-cycle strobe, result_valid; the receiver cannot stall.
//  - One command is in flight: busy holds from the accepting edge until the
//    strobe cycle, in which the next command can already be taken.
//  - Plain get: hand-off, directory read and segment-depth read, then each
//    slot in turn is read and checked through the slot memory's single
//    read port; a hit ends the scan early. A put adds a grow step.
//  - A split walks the whole segment, a read step and a write step per
//    slot, redirects one directory entry per cycle, then retries; a
//    doubling copies the directory entry by entry, read then write, then retries.
//  - Reset, and any configuration write, rebuild the table: a clearing pass
//    writes one slot per cycle, with the directory and segment depths
//    alongside, over every slot address; busy stays high during the pass.
//  - Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// ----------------------------------------------------------------------------
`include "extendible_hash_table_core_assert.svh"
module extendible_hash_table_core import eht_pkg::*; #(
  parameter int BUCKET_SLOTS      = BucketSlots,
  parameter int BUCKET_INDEX_BITS = BucketIndexBits,
  parameter int MAX_GLOBAL_DEPTH  = MaxGlobalDepth,
  parameter int MAX_SEGMENTS      = MaxSegments
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        result_valid,
  output logic [63:0] read_value,
  output logic        hit,
  output logic        status
);
  logic [2:0] init_depth;
  logic [6:0] key_bits;
  logic [6:0] kb;
  logic       rebuild;
  logic       qfull, avail, pop, bbusy, push;
  req_t       head, inreq;

  // Hold the configuration registers; any write rebuilds the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_depth <= 3'd0;
      key_bits   <= 7'd64;
      rebuild    <= 1'b0;
    end else begin
      rebuild <= cfg_we;
      if (cfg_we && cfg_index == CFG_INIT_DEPTH) init_depth <= cfg_data[2:0];
      if (cfg_we && cfg_index == CFG_KEY_BITS)   key_bits   <= cfg_data;
    end
  end

  assign kb = (key_bits == 7'd0) ? 7'd1 : (key_bits > 7'd64 ? 7'd64 : key_bits);
  // One command in flight: refuse start until the engine has finished.
  assign busy  = qfull | avail | bbusy | rebuild;
  assign push  = start & ~busy;
  assign inreq = '{op: op, key: key, value: value};

  eht_front u_front (
    .clk(clk), .rst(rst), .push(push), .push_req(inreq), .full(qfull),
    .pop(pop), .avail(avail), .head(head)
  );

  eht_back #(
    .BUCKET_SLOTS(BUCKET_SLOTS), .BUCKET_INDEX_BITS(BUCKET_INDEX_BITS),
    .MAX_GLOBAL_DEPTH(MAX_GLOBAL_DEPTH), .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_back (
    .clk(clk), .rst(rst), .rebuild(rebuild), .init_depth(init_depth), .kb(kb),
    .avail(avail), .req(head), .pop(pop), .busy(bbusy), .done(result_valid),
    .read_value(read_value), .hit(hit), .status(status)
  );

  `EHT_ASSERT_IMPL(a_no_push_busy, clk, rst, push, !avail)
  `EHT_ASSERT_IMPL(a_pop_avail, clk, rst, pop, avail)
  `EHT_ASSERT_NEVER(a_q_over, clk, rst, push && qfull)
endmodule

@@ hw/rtl/eht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eht_ram
// Generic single-port write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module eht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/eht_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eht_front
// Request queue: take transactions from the command port, hold them for the
// engine.
// ----------------------------------------------------------------------------
module eht_front import eht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  req_t  push_req,
  output logic  full,
  input  logic  pop,
  output logic  avail,
  output req_t  head
);
  req_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign avail = (cnt != 2'd0);
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_req;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ hw/rtl/eht_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eht_back
// Table engine: lookup, insert, segment split, directory doubling, clear.
// ----------------------------------------------------------------------------
`include "extendible_hash_table_core_assert.svh"
module eht_back import eht_pkg::*; #(
  parameter int BUCKET_SLOTS      = BucketSlots,
  parameter int BUCKET_INDEX_BITS = BucketIndexBits,
  parameter int MAX_GLOBAL_DEPTH  = MaxGlobalDepth,
  parameter int MAX_SEGMENTS      = MaxSegments
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rebuild,
  input  logic [2:0]  init_depth,
  input  logic [6:0]  kb,
  input  logic        avail,
  input  req_t        req,
  output logic        pop,
  output logic        busy,
  output logic        done,
  output logic [63:0] read_value,
  output logic        hit,
  output logic        status
);
  localparam int SegW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SlotW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int DirN   = 1 << MAX_GLOBAL_DEPTH;
  localparam int DirW   = MAX_GLOBAL_DEPTH;
  localparam int NBkt   = 1 << BUCKET_INDEX_BITS;
  localparam int AddrW  = SegW + BUCKET_INDEX_BITS + SlotW;
  localparam int Depth  = 1 << AddrW;
  localparam int ClrN   = (Depth > DirN) ? Depth : DirN;
  localparam int GdW    = $clog2(MAX_GLOBAL_DEPTH + 1);
  localparam int CntW   = SegW + 1;
  localparam int SweepW = $clog2(ClrN) + 1;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DIR   = 14'b00000000000100,
    S_SEG   = 14'b00000000001000,
    S_DEP   = 14'b00000000010000,
    S_READ  = 14'b00000000100000,
    S_CHECK = 14'b00000001000000,
    S_GROW  = 14'b00000010000000,
    S_SPRD  = 14'b00000100000000,
    S_SPWR  = 14'b00001000000000,
    S_REDIR = 14'b00010000000000,
    S_DBLR  = 14'b00100000000000,
    S_DBLW  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } st_t;

  st_t               st;
  logic [GdW-1:0]    gd;
  logic [CntW-1:0]   nfree;
  logic [SweepW-1:0] sweep;
  logic [SlotW:0]    sidx;
  logic [SlotW:0]    pos;
  logic [SegW-1:0]   seg;
  logic [GdW-1:0]    sd;
  logic [DirW-1:0]   dix;
  logic [SegW-1:0]   nseg;
  logic [SlotW:0]    wcnt;
  logic [DirW:0]     ridx;

  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [127:0]      wdata;
  logic [AddrW-1:0]  raddr;
  logic [127:0]      rdata;
  logic              dir_we;
  logic [DirW-1:0]   dir_waddr;
  logic [SegW-1:0]   dir_wdata;
  logic [DirW-1:0]   dir_raddr;
  logic [SegW-1:0]   dir_rdata;
  logic              sd_we;
  logic [SegW-1:0]   sd_waddr;
  logic [GdW-1:0]    sd_wdata;
  logic [GdW-1:0]    sd_rdata;
  logic              split_go;
  logic [BUCKET_INDEX_BITS-1:0] bkt;
  logic [15:0]       pfx_g;
  logic [15:0]       pfx_r;
  logic [15:0]       pfx_k;
  logic [15:0]       pfx_rg;
  logic [GdW-1:0]    d0;
  logic [DirW-1:0]   stride_m;
  logic [DirW:0]     mid;
  logic [DirW:0]     rgt;

  eht_ram #(.Width(128), .Depth(Depth)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Directory: segment number per prefix.
  eht_ram #(.Width(SegW), .Depth(DirN)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  // Local depth per segment, read at the segment the directory just named.
  eht_ram #(.Width(GdW), .Depth(MAX_SEGMENTS)) u_sdep (
    .clk(clk), .we(sd_we), .waddr(sd_waddr), .wdata(sd_wdata),
    .raddr(dir_rdata), .rdata(sd_rdata)
  );

  assign bkt    = req.key[BUCKET_INDEX_BITS-1:0];
  assign pfx_g  = prefix_of(req.key, kb, 5'(gd));
  assign pfx_k  = prefix_of(req.key, kb, 5'(sd));
  assign pfx_r  = prefix_of(rdata[127:64], kb, 5'(sd));
  assign pfx_rg = prefix_of(rdata[127:64], kb, 5'(gd));
  assign stride_m = DirW'((({(DirW+1){1'b0}} | 1'b1) << (gd - sd)) - 1'b1);
  assign mid    = {1'b0, dix & ~stride_m} + (({1'b0, stride_m} + 1'b1) >> 1);
  assign rgt    = {1'b0, dix & ~stride_m} + {1'b0, stride_m} + 1'b1;
  assign busy   = (st != S_IDLE);
  assign pop    = (st == S_DONE);
  assign split_go = (st == S_GROW) && (pos > (SlotW+1)'(BUCKET_SLOTS - 1)) &&
                    (sd < gd) && (nfree < CntW'(MAX_SEGMENTS));

  always_comb begin
    d0 = (32'(init_depth) > MAX_GLOBAL_DEPTH) ? GdW'(MAX_GLOBAL_DEPTH) : GdW'(init_depth);
    for (int i = 0; i < 8; i++) begin
      if (d0 > 0 && (32'd1 << d0) > 32'(MAX_SEGMENTS)) d0 = d0 - 1'b1;
    end
  end

  always_comb begin
    raddr = {seg, bkt, sidx[SlotW-1:0]};
    we    = 1'b0;
    waddr = {seg, bkt, pos[SlotW-1:0]};
    wdata = {req.key, req.value};
    if (st == S_SPRD || st == S_SPWR) begin
      raddr = {seg, sweep[BUCKET_INDEX_BITS+SlotW-1:SlotW], sidx[SlotW-1:0]};
    end
    if (st == S_CLEAR) begin
      we = (sweep < SweepW'(Depth)); waddr = sweep[AddrW-1:0]; wdata = '0;
    end else if (st == S_GROW && pos <= (SlotW+1)'(BUCKET_SLOTS - 1)) begin
      we = 1'b1;
    end else if (st == S_SPWR && {1'b0, pfx_rg} >= 17'(mid)) begin
      we = 1'b1;
      waddr = {nseg, sweep[BUCKET_INDEX_BITS+SlotW-1:SlotW], wcnt[SlotW-1:0]};
      wdata = rdata;
    end
  end

  // Directory and segment-depth writes: clear pass, split, doubling.
  always_comb begin
    dir_raddr = pfx_g[DirW-1:0];
    dir_we    = 1'b0;
    dir_waddr = ridx[DirW-1:0];
    dir_wdata = nseg;
    sd_we     = 1'b0;
    sd_waddr  = nseg;
    sd_wdata  = sd + 1'b1;
    if (st == S_DBLR) dir_raddr = ridx[DirW:1];
    if (st == S_CLEAR) begin
      if (sweep < SweepW'(DirN)) begin
        dir_we    = 1'b1;
        dir_waddr = sweep[DirW-1:0];
        dir_wdata = (sweep < SweepW'(MAX_SEGMENTS)) ? sweep[SegW-1:0] : '0;
      end
      if (sweep < SweepW'(MAX_SEGMENTS)) begin
        sd_we    = 1'b1;
        sd_waddr = sweep[SegW-1:0];
        sd_wdata = d0;
      end
    end else if (st == S_REDIR) begin
      dir_we = 1'b1;
      sd_we  = 1'b1;
    end else if (st == S_DBLW) begin
      dir_we    = 1'b1;
      dir_wdata = dir_rdata;
    end else if (split_go) begin
      sd_we    = 1'b1;
      sd_waddr = seg;
    end
  end

  always_ff @(posedge clk) begin
    done <= !(rst || rebuild) && (st == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst || rebuild) begin
      st    <= S_CLEAR;
      sweep <= '0;
      gd    <= d0;
      nfree <= CntW'(32'd1 << d0);
    end else begin
      unique case (st)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SweepW'(ClrN - 1)) st <= S_IDLE;
        end
        S_IDLE: if (avail) st <= S_DIR;
        S_DIR: begin
          dix   <= pfx_g[DirW-1:0];
          sidx  <= '0;
          pos   <= (SlotW+1)'(BUCKET_SLOTS);
          st    <= S_SEG;
        end
        S_SEG: begin
          seg <= dir_rdata;
          st  <= S_DEP;
        end
        S_DEP: begin
          sd <= sd_rdata;
          st <= S_CHECK;
        end
        S_READ: st <= S_CHECK;
        S_CHECK: begin
          if (rdata[127:64] == req.key) begin
            pos   <= sidx;
            st    <= (req.op == OP_PUT) ? S_GROW : S_DONE;
            read_value <= (req.op == OP_PUT) ? 64'd0 : rdata[63:0];
            hit   <= 1'b1;
            status <= 1'b0;
          end else begin
            if (pos == (SlotW+1)'(BUCKET_SLOTS) &&
                (rdata == 128'd0 || pfx_k != pfx_r)) pos <= sidx;
            if (sidx == (SlotW+1)'(BUCKET_SLOTS - 1)) begin
              read_value <= 64'd0;
              hit <= 1'b0;
              status <= 1'b0;
              st <= (req.op == OP_PUT) ? S_GROW : S_DONE;
            end else begin
              sidx <= sidx + 1'b1;
              st   <= S_READ;
            end
          end
        end
        S_GROW: begin
          if (pos <= (SlotW+1)'(BUCKET_SLOTS - 1)) begin
            st <= S_DONE;
          end else if (sd < gd) begin
            if (nfree >= CntW'(MAX_SEGMENTS)) begin
              status <= 1'b1; st <= S_DONE;
            end else begin
              nseg  <= nfree[SegW-1:0];
              nfree <= nfree + 1'b1;
              sweep <= '0; sidx <= '0; wcnt <= '0;
              st <= S_SPRD;
            end
          end else if (gd >= GdW'(MAX_GLOBAL_DEPTH)) begin
            status <= 1'b1; st <= S_DONE;
          end else begin
            ridx <= (DirW+1)'((32'd1 << (32'(gd) + 32'd1)) - 32'd1);
            st   <= S_DBLR;
          end
        end
        S_SPRD: st <= S_SPWR;
        S_SPWR: begin
          if (sidx == (SlotW+1)'(BUCKET_SLOTS - 1)) begin
            sidx <= '0; wcnt <= '0;
            sweep <= sweep + (SweepW'(1) << SlotW);
            if (sweep[BUCKET_INDEX_BITS+SlotW-1:SlotW] == BUCKET_INDEX_BITS'(NBkt - 1)) begin
              ridx <= mid;
              st   <= S_REDIR;
            end else begin
              st <= S_SPRD;
            end
          end else begin
            if (we) wcnt <= wcnt + 1'b1;
            sidx <= sidx + 1'b1;
            st <= S_SPRD;
          end
        end
        // Point the upper half of the range at the new segment, one entry
        // per cycle.
        S_REDIR: begin
          if (ridx + 1'b1 == rgt) st <= S_DIR;
          else ridx <= ridx + 1'b1;
        end
        // Copy entry i/2 into entry i, top down, so each source is read
        // before it is overwritten.
        S_DBLR: st <= S_DBLW;
        S_DBLW: begin
          if (ridx == '0) begin
            gd <= gd + 1'b1;
            st <= S_DIR;
          end else begin
            ridx <= ridx - 1'b1;
            st   <= S_DBLR;
          end
        end
        S_DONE: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  `EHT_ASSERT_IMPL(a_done_one, clk, rst, done, !$past(done))
  `EHT_ASSERT_NEVER(a_gd_max, clk, rst, gd > GdW'(MAX_GLOBAL_DEPTH))
  `EHT_ASSERT_IMPL(a_status_put, clk, rst, done && status, !hit)
endmodule
